/* sv/ssd_command_buffer_erase_coalescer_defines.svh */
// assertion macros for the erase coalescing command buffer
// no dependencies; included by the modules that carry assertions
`ifndef SSD_COMMAND_BUFFER_ERASE_COALESCER_DEFINES_SVH
`define SSD_COMMAND_BUFFER_ERASE_COALESCER_DEFINES_SVH

`ifndef SYNTH

`define SECB_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("secb assertion failed");

`define SECB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("secb assertion failed");

`else

`define SECB_ASSERT_IMPL(name, clk, rst, ante, cons)

`define SECB_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* sv/secb_pkg.sv */
// types, codes and constants of the erase coalescing command buffer
// no dependencies; used by every module of the block but secb_ram
package secb_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int ADDR_BITS_DEFAULT = 16;

   localparam int LBA_W   = 16;
   localparam int DATA_W  = 32;
   localparam int SIZE_W  = 16;
   localparam int LEN_W   = 17;
   localparam int IDX_W   = 4;
   localparam int COUNT_W = 5;
   localparam int THR_W   = 5;

   localparam logic [THR_W-1:0] THRESH_RESET = 5'd10;
   localparam logic [LEN_W-1:0] LEN_MAX      = 17'h1FFFF;

   // entry kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_ERASE = 1'b1;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_MERGE  = 2'd1,
      FUNC_FLUSH  = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef struct packed {
      logic capture;
      logic do_append;
      logic do_flush;
      logic do_read;
      logic merge_start;
      logic merge_step;
      logic rsp_load;
   } secb_cmd_type;

   typedef struct packed {
      func_type func;
      logic     count_zero;
      logic     merge_last;
      logic     rsp_free;
   } secb_sts_type;

endpackage

/* sv/ssd_command_buffer_erase_coalescer.sv */
// erase coalescing command buffer, top level; depends on secb_pkg, secb_ctrl, secb_datapath
// append, flush and read: exec state, then result state, where the result is registered once the output
// register is free; erase-merge: exec state, one merge step per stored entry, then the result state
// a result waits in the output register while the next transaction is taken
// synchronous active-high reset empties the list, sets the threshold to 10, drops any result
module ssd_command_buffer_erase_coalescer #(
   parameter int DEPTH     = secb_pkg::DEPTH_DEFAULT,
   parameter int ADDR_BITS = secb_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic                           req_command_kind,
   input  logic [secb_pkg::LBA_W-1:0]     req_lba,
   input  logic [secb_pkg::DATA_W-1:0]    req_write_data,
   input  logic [secb_pkg::SIZE_W-1:0]    req_erase_size,
   input  logic [secb_pkg::IDX_W-1:0]     req_entry_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [secb_pkg::THR_W-1:0]     csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_merged,
   output logic [secb_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                           rsp_buffer_full,
   output logic                           rsp_overflow,
   output logic                           rsp_read_valid,
   output logic                           rsp_read_kind,
   output logic [secb_pkg::LBA_W-1:0]     rsp_read_lba,
   output logic [secb_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [secb_pkg::LEN_W-1:0]     rsp_read_size
);

   secb_pkg::secb_cmd_type cmd;
   secb_pkg::secb_sts_type sts;

   secb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   secb_datapath #(
      .DEPTH     (DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_command_kind (req_command_kind),
      .req_lba          (req_lba),
      .req_write_data   (req_write_data),
      .req_erase_size   (req_erase_size),
      .req_entry_index  (req_entry_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged       (rsp_merged),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_buffer_full  (rsp_buffer_full),
      .rsp_overflow     (rsp_overflow),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_kind    (rsp_read_kind),
      .rsp_read_lba     (rsp_read_lba),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_size    (rsp_read_size)
   );

endmodule

/* sv/secb_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module secb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/secb_ctrl.sv */
// controller state machine of the erase coalescing command buffer
// depends on secb_pkg and the assertion macro header
`include "ssd_command_buffer_erase_coalescer_defines.svh"

module secb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  secb_pkg::secb_sts_type sts,
   output secb_pkg::secb_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_MERGE  = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESULT;
            unique case (sts.func)
               secb_pkg::FUNC_APPEND: cmd.do_append = 1'b1;
               secb_pkg::FUNC_FLUSH:  cmd.do_flush  = 1'b1;
               secb_pkg::FUNC_READ:   cmd.do_read   = 1'b1;
               secb_pkg::FUNC_MERGE: begin
                  cmd.merge_start = 1'b1;
                  if (!sts.count_zero) begin
                     state_in = S_MERGE;
                  end
               end
               default: state_in = S_RESULT;
            endcase
         end
         S_MERGE: begin
            cmd.merge_step = 1'b1;
            if (sts.merge_last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SECB_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall, state_ff == S_EXEC)
   `SECB_ASSERT_IMPL(a_onehot_state, clock, reset, 1'b1, $onehot(state_ff))
   `SECB_ASSERT_IMPL(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall)

endmodule

/* sv/secb_datapath.sv */
// datapath of the erase coalescing command buffer: entry store, merge walk,
// count, threshold register and result register; depends on secb_pkg, secb_ram and the macro header
`include "ssd_command_buffer_erase_coalescer_defines.svh"

module secb_datapath #(
   parameter int DEPTH     = secb_pkg::DEPTH_DEFAULT,
   parameter int ADDR_BITS = secb_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  secb_pkg::secb_cmd_type         cmd,
   output secb_pkg::secb_sts_type         sts,
   input  logic [1:0]                     req_func,
   input  logic                           req_command_kind,
   input  logic [secb_pkg::LBA_W-1:0]     req_lba,
   input  logic [secb_pkg::DATA_W-1:0]    req_write_data,
   input  logic [secb_pkg::SIZE_W-1:0]    req_erase_size,
   input  logic [secb_pkg::IDX_W-1:0]     req_entry_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [secb_pkg::THR_W-1:0]     csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_merged,
   output logic [secb_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                           rsp_buffer_full,
   output logic                           rsp_overflow,
   output logic                           rsp_read_valid,
   output logic                           rsp_read_kind,
   output logic [secb_pkg::LBA_W-1:0]     rsp_read_lba,
   output logic [secb_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [secb_pkg::LEN_W-1:0]     rsp_read_size
);

   localparam int IDXW  = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam int LEN_W = secb_pkg::LEN_W;
   localparam int DAT_W = secb_pkg::DATA_W;
   localparam int ENT_W = 1 + ADDR_BITS + DAT_W + LEN_W;
   localparam int EW    = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
   localparam int FW    = (CNTW > secb_pkg::THR_W) ? CNTW : secb_pkg::THR_W;
   localparam int RW    = (CNTW > secb_pkg::IDX_W) ? CNTW : secb_pkg::IDX_W;

   // latched transaction
   secb_pkg::func_type             func_ff;
   logic                           kind_ff;
   logic [secb_pkg::LBA_W-1:0]     lba_ff;
   logic [DAT_W-1:0]               data_ff;
   logic [secb_pkg::SIZE_W-1:0]    size_ff;
   logic [secb_pkg::IDX_W-1:0]     idx_ff;

   logic [CNTW-1:0]                count_ff, count_in;
   logic [IDXW-1:0]                p_ff, p_in;
   logic [CNTW-1:0]                wr_ff, wr_in;
   logic                           any_ff, any_in;
   logic                           ovf_ff, ovf_in;
   logic [secb_pkg::THR_W-1:0]     thr_ff, thr_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           merged_ff;
   logic [secb_pkg::COUNT_W-1:0]   count_out_ff;
   logic                           full_ff;
   logic                           overflow_ff;
   logic                           rvalid_ff;
   logic                           rkind_ff;
   logic [secb_pkg::LBA_W-1:0]     rlba_ff;
   logic [DAT_W-1:0]               rdata_ff;
   logic [LEN_W-1:0]               rsize_ff;

   logic                           ram_wr_en;
   logic [IDXW-1:0]                ram_wr_addr;
   logic [ENT_W-1:0]               ram_wr_data;
   logic                           ram_rd_en;
   logic [IDXW-1:0]                ram_rd_addr;
   logic [ENT_W-1:0]               ram_rd_data;

   logic                           ent_kind;
   logic [ADDR_BITS-1:0]           ent_addr;
   logic [DAT_W-1:0]               ent_word;
   logic [LEN_W-1:0]               ent_len;
   logic [EW-1:0]                  s_val, e_val, tlo, thi, nl;
   logic                           grow_end, grow_start, widened, keep;
   logic [LEN_W-1:0]               sat_len;
   logic [ENT_W-1:0]               new_ent, upd_ent;
   logic                           depth_full, merge_last, rsp_free, read_hit;

   assign csr_ready = 1'b1;

   // stored entry fields
   assign ent_len  = ram_rd_data[LEN_W-1:0];
   assign ent_word = ram_rd_data[LEN_W+DAT_W-1:LEN_W];
   assign ent_addr = ram_rd_data[LEN_W+DAT_W+ADDR_BITS-1:LEN_W+DAT_W];
   assign ent_kind = ram_rd_data[ENT_W-1];

   // merge evaluation of the entry just read
   always_comb begin
      s_val      = EW'(ent_addr);
      e_val      = s_val + EW'(ent_len);
      tlo        = EW'(lba_ff);
      thi        = EW'(lba_ff) + EW'(size_ff);
      grow_end   = (s_val <= tlo) && (tlo <= e_val) && (e_val < thi);
      grow_start = (tlo <= s_val) && (s_val <= thi) && (thi < e_val);
      nl         = grow_end ? (thi - s_val) : (e_val - tlo);
      sat_len    = (nl > EW'(secb_pkg::LEN_MAX)) ? secb_pkg::LEN_MAX : LEN_W'(nl);
      widened    = (ent_kind == secb_pkg::KIND_ERASE) && (grow_end || grow_start);
      keep       = !((ent_kind == secb_pkg::KIND_WRITE) && (tlo <= s_val) && (s_val < thi));
      upd_ent    = {ent_kind,
                    (widened && !grow_end) ? ADDR_BITS'(lba_ff) : ent_addr,
                    ent_word,
                    widened ? sat_len : ent_len};
      new_ent    = {kind_ff,
                    ADDR_BITS'(lba_ff),
                    (kind_ff == secb_pkg::KIND_ERASE) ? '0 : data_ff,
                    (kind_ff == secb_pkg::KIND_ERASE) ? LEN_W'(size_ff) : '0};
   end

   assign depth_full = count_ff >= CNTW'(DEPTH);
   assign merge_last = (CNTW'(p_ff) + CNTW'(1)) == count_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign read_hit   = RW'(idx_ff) < RW'(count_ff);

   assign sts.func       = func_ff;
   assign sts.count_zero = count_ff == '0;
   assign sts.merge_last = merge_last;
   assign sts.rsp_free   = rsp_free;

   // ram ports
   always_comb begin
      ram_wr_en   = (cmd.do_append && !depth_full) || (cmd.merge_step && keep);
      ram_wr_addr = cmd.do_append ? count_ff[IDXW-1:0] : wr_ff[IDXW-1:0];
      ram_wr_data = cmd.do_append ? new_ent : upd_ent;
      ram_rd_en   = 1'b0;
      ram_rd_addr = IDXW'(idx_ff);
      priority if (cmd.do_read) begin
         ram_rd_en = 1'b1;
      end else if (cmd.merge_start) begin
         ram_rd_en   = count_ff != '0;
         ram_rd_addr = '0;
      end else if (cmd.merge_step) begin
         ram_rd_en   = !merge_last;
         ram_rd_addr = p_ff + IDXW'(1);
      end
   end

   secb_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control state next values
   always_comb begin
      count_in = count_ff;
      p_in     = p_ff;
      wr_in    = wr_ff;
      any_in   = any_ff;
      ovf_in   = ovf_ff;
      thr_in   = (csr_valid && csr_ready) ? csr_wdata : thr_ff;
      priority if (cmd.do_flush) begin
         count_in = '0;
      end else if (cmd.do_append) begin
         ovf_in = depth_full;
         if (!depth_full) begin
            count_in = count_ff + CNTW'(1);
         end
      end else if (cmd.merge_start) begin
         p_in   = '0;
         wr_in  = '0;
         any_in = 1'b0;
      end else if (cmd.merge_step) begin
         p_in   = p_ff + IDXW'(1);
         wr_in  = wr_ff + CNTW'(keep);
         any_in = any_ff || widened;
         if (merge_last) begin
            count_in = wr_ff + CNTW'(keep);
         end
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         p_ff         <= '0;
         wr_ff        <= '0;
         any_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         thr_ff       <= secb_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         p_ff         <= p_in;
         wr_ff        <= wr_in;
         any_ff       <= any_in;
         ovf_ff       <= ovf_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= secb_pkg::func_type'(req_func);
         kind_ff <= req_command_kind;
         lba_ff  <= req_lba;
         data_ff <= req_write_data;
         size_ff <= req_erase_size;
         idx_ff  <= req_entry_index;
      end
      if (cmd.rsp_load) begin
         merged_ff    <= (func_ff == secb_pkg::FUNC_MERGE) && any_ff;
         count_out_ff <= secb_pkg::COUNT_W'(count_ff);
         full_ff      <= FW'(count_ff) >= FW'(thr_ff);
         overflow_ff  <= (func_ff == secb_pkg::FUNC_APPEND) && ovf_ff;
         rvalid_ff    <= (func_ff == secb_pkg::FUNC_READ) && read_hit;
         if ((func_ff == secb_pkg::FUNC_READ) && read_hit) begin
            rkind_ff <= ent_kind;
            rlba_ff  <= secb_pkg::LBA_W'(ent_addr);
            rdata_ff <= (ent_kind == secb_pkg::KIND_WRITE) ? ent_word : '0;
            rsize_ff <= (ent_kind == secb_pkg::KIND_ERASE) ? ent_len : '0;
         end else begin
            rkind_ff <= 1'b0;
            rlba_ff  <= '0;
            rdata_ff <= '0;
            rsize_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_merged      = merged_ff;
   assign rsp_entry_count = count_out_ff;
   assign rsp_buffer_full = full_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_read_valid  = rvalid_ff;
   assign rsp_read_kind   = rkind_ff;
   assign rsp_read_lba    = rlba_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_read_size   = rsize_ff;

   `SECB_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(DEPTH))
   `SECB_ASSERT_IMPL(a_wr_behind, clock, reset, cmd.merge_step, wr_ff <= CNTW'(p_ff))
   `SECB_ASSERT_NEXT(a_merge_shrinks, clock, reset, cmd.merge_step && merge_last, count_ff <= $past(count_ff))
   `SECB_ASSERT_NEXT(a_count_hold, clock, reset, !cmd.do_append && !cmd.do_flush && !cmd.merge_step, $stable(count_ff))

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// testbench for ssd_command_buffer_erase_coalescer: directed and random command traffic
// checked against a shadow copy of the command list; depends on secb_pkg and the block's rtl
module testbench;

   localparam int BUF_DEPTH     = secb_pkg::DEPTH_DEFAULT;
   localparam int LBA_W         = secb_pkg::LBA_W;
   localparam int DATA_W        = secb_pkg::DATA_W;
   localparam int SIZE_W        = secb_pkg::SIZE_W;
   localparam int LEN_W         = secb_pkg::LEN_W;
   localparam int IDX_W         = secb_pkg::IDX_W;
   localparam int COUNT_W       = secb_pkg::COUNT_W;
   localparam int THR_W         = secb_pkg::THR_W;
   localparam logic [LEN_W-1:0] LEN_MAX = secb_pkg::LEN_MAX;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      secb_pkg::func_type func;
      logic               kind;
      logic [LBA_W-1:0]   lba;
      logic [DATA_W-1:0]  data;
      logic [SIZE_W-1:0]  size;
      logic [IDX_W-1:0]   idx;
   } buf_request_type;

   typedef struct packed {
      logic               merged;
      logic [COUNT_W-1:0] entry_count;
      logic               full;
      logic               overflow;
      logic               read_valid;
      logic               read_kind;
      logic [LBA_W-1:0]   read_lba;
      logic [DATA_W-1:0]  read_data;
      logic [LEN_W-1:0]   read_size;
   } buf_response_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func         = '0;
   logic                req_command_kind = 1'b0;
   logic [LBA_W-1:0]    req_lba          = '0;
   logic [DATA_W-1:0]   req_write_data   = '0;
   logic [SIZE_W-1:0]   req_erase_size   = '0;
   logic [IDX_W-1:0]    req_entry_index  = '0;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [THR_W-1:0]    csr_wdata        = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic                rsp_merged;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_buffer_full;
   logic                rsp_overflow;
   logic                rsp_read_valid;
   logic                rsp_read_kind;
   logic [LBA_W-1:0]    rsp_read_lba;
   logic [DATA_W-1:0]   rsp_read_data;
   logic [LEN_W-1:0]    rsp_read_size;

   // shadow copy of the command list
   logic                shadow_kind [BUF_DEPTH];
   logic [LBA_W-1:0]    shadow_lba  [BUF_DEPTH];
   logic [DATA_W-1:0]   shadow_word [BUF_DEPTH];
   logic [LEN_W-1:0]    shadow_len  [BUF_DEPTH];
   int unsigned         shadow_count     = 0;
   int unsigned         shadow_threshold = 32'(secb_pkg::THRESH_RESET);

   buf_response_type    pending_responses[$];
   int                  failures      = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct     = 0;
   int                  hold_left     = 0;
   logic                hold_go       = 1'b0;
   logic                hold_taken    = 1'b0;
   int                  cycle_count   = 0;

   ssd_command_buffer_erase_coalescer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_command_kind (req_command_kind),
      .req_lba          (req_lba),
      .req_write_data   (req_write_data),
      .req_erase_size   (req_erase_size),
      .req_entry_index  (req_entry_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged       (rsp_merged),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_buffer_full  (rsp_buffer_full),
      .rsp_overflow     (rsp_overflow),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_kind    (rsp_read_kind),
      .rsp_read_lba     (rsp_read_lba),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_size    (rsp_read_size)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // drops covered writes and widens erases that overlap the target on one side
   function automatic logic coalesce_erases(int unsigned t_lo, int unsigned t_hi);
      int unsigned       wr;
      int unsigned       s;
      int unsigned       e;
      int unsigned       nl;
      logic              widened;
      logic              k;
      logic [LBA_W-1:0]  a;
      logic [DATA_W-1:0] w;
      logic [LEN_W-1:0]  len;
      wr = 0;
      widened = 1'b0;
      for (int rd = 0; rd < shadow_count; rd++) begin
         k = shadow_kind[rd];
         a = shadow_lba[rd];
         w = shadow_word[rd];
         len = shadow_len[rd];
         if (k == secb_pkg::KIND_WRITE) begin
            if (t_lo <= 32'(a) && 32'(a) < t_hi)
               continue;
         end else begin
            s = 32'(a);
            e = s + 32'(len);
            if (s <= t_lo && t_lo <= e && e < t_hi) begin
               nl = t_hi - s;
               len = (nl > 32'(LEN_MAX)) ? LEN_MAX : nl[LEN_W-1:0];
               widened = 1'b1;
            end else if (t_lo <= s && s <= t_hi && t_hi < e) begin
               nl = e - t_lo;
               a = t_lo[LBA_W-1:0];
               len = (nl > 32'(LEN_MAX)) ? LEN_MAX : nl[LEN_W-1:0];
               widened = 1'b1;
            end
         end
         shadow_kind[wr] = k;
         shadow_lba[wr] = a;
         shadow_word[wr] = w;
         shadow_len[wr] = len;
         wr++;
      end
      shadow_count = wr;
      return widened;
   endfunction

   function automatic buf_response_type apply_command(buf_request_type r);
      buf_response_type p;
      int unsigned      t_lo;
      p = '0;
      unique case (r.func)
         secb_pkg::FUNC_APPEND: begin
            if (shadow_count >= BUF_DEPTH) begin
               p.overflow = 1'b1;
            end else begin
               shadow_kind[shadow_count] = r.kind;
               shadow_lba[shadow_count] = r.lba;
               shadow_word[shadow_count] = (r.kind == secb_pkg::KIND_ERASE) ? '0 : r.data;
               shadow_len[shadow_count] = (r.kind == secb_pkg::KIND_ERASE) ?
                                          LEN_W'(r.size) : '0;
               shadow_count++;
            end
         end
         secb_pkg::FUNC_MERGE: begin
            t_lo = 32'(r.lba);
            p.merged = coalesce_erases(t_lo, t_lo + 32'(r.size));
         end
         secb_pkg::FUNC_FLUSH: begin
            shadow_count = 0;
         end
         secb_pkg::FUNC_READ: begin
            if (32'(r.idx) < shadow_count) begin
               p.read_valid = 1'b1;
               p.read_kind = shadow_kind[r.idx];
               p.read_lba = shadow_lba[r.idx];
               p.read_data = (shadow_kind[r.idx] == secb_pkg::KIND_ERASE) ?
                             '0 : shadow_word[r.idx];
               p.read_size = (shadow_kind[r.idx] == secb_pkg::KIND_ERASE) ?
                             shadow_len[r.idx] : '0;
            end
         end
      endcase
      p.entry_count = shadow_count[COUNT_W-1:0];
      p.full = (shadow_count >= shadow_threshold);
      return p;
   endfunction

   function automatic buf_request_type make_request(secb_pkg::func_type func, logic kind,
                                                    logic [LBA_W-1:0] lba,
                                                    logic [DATA_W-1:0] data,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [IDX_W-1:0] idx);
      buf_request_type r;
      r.func = func;
      r.kind = kind;
      r.lba = lba;
      r.data = data;
      r.size = size;
      r.idx = idx;
      return r;
   endfunction

   // mostly clustered addresses so that merge targets meet stored entries
   function automatic buf_request_type random_request();
      buf_request_type r;
      int unsigned     pick;
      pick = $urandom_range(99);
      r.kind = 1'($urandom_range(1));
      r.data = $urandom;
      r.idx = IDX_W'($urandom_range(15));
      if ($urandom_range(99) < 70) begin
         r.lba = LBA_W'($urandom_range(63));
         r.size = SIZE_W'($urandom_range(24));
      end else begin
         r.lba = LBA_W'($urandom);
         r.size = SIZE_W'($urandom);
      end
      if (pick < 52) begin
         r.func = secb_pkg::FUNC_APPEND;
      end else if (pick < 72) begin
         r.func = secb_pkg::FUNC_MERGE;
      end else if (pick < 97) begin
         r.func = secb_pkg::FUNC_READ;
         if (shadow_count != 0 && $urandom_range(99) < 80)
            r.idx = IDX_W'($urandom_range(shadow_count - 1));
      end else begin
         r.func = secb_pkg::FUNC_FLUSH;
      end
      return r;
   endfunction

   task automatic send_request(buf_request_type r);
      int               gap;
      buf_response_type want;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= r.func;
      req_command_kind <= r.kind;
      req_lba <= r.lba;
      req_write_data <= r.data;
      req_erase_size <= r.size;
      req_entry_index <= r.idx;
      do @(posedge clock); while (req_stall);
      want = apply_command(r);
      pending_responses.insert(pending_responses.size(), want);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_threshold = 32'(value);
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0h actual %0h", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : check_response
      buf_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $display("%0t unexpected transaction, expected none actual count %0d",
                     $time, rsp_entry_count);
            failures++;
         end else begin
            want = pending_responses.pop_front();
            check_field("merged", 32'(want.merged), 32'(rsp_merged));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            check_field("buffer_full", 32'(want.full), 32'(rsp_buffer_full));
            check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
            check_field("read_valid", 32'(want.read_valid), 32'(rsp_read_valid));
            check_field("read_kind", 32'(want.read_kind), 32'(rsp_read_kind));
            check_field("read_lba", 32'(want.read_lba), 32'(rsp_read_lba));
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("read_size", 32'(want.read_size), 32'(rsp_read_size));
         end
      end
   end

   // receiver back-pressure, with a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL ssd_command_buffer_erase_coalescer");
         $finish;
      end
   end

   task automatic test_fill_and_overflow();
      for (int i = 0; i < BUF_DEPTH; i++) begin
         unique case (i)
            0: send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_WRITE,
                                         '0, '0, '0, '0));
            1: send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_ERASE,
                                         '1, '1, '1, '1));
            2: send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_WRITE,
                                         '1, '1, '0, '0));
            3: send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_ERASE,
                                         '0, '0, '0, '0));
            default: send_request(make_request(secb_pkg::FUNC_APPEND,
                                               1'($urandom_range(1)),
                                               LBA_W'($urandom), $urandom,
                                               SIZE_W'($urandom), '0));
         endcase
      end
      send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_WRITE, 16'h1234,
                                32'h5a5a_a5a5, '0, '0));
      send_request(make_request(secb_pkg::FUNC_READ, secb_pkg::KIND_WRITE, '0, '0, '0, '1));
   endtask

   task automatic test_merge_rules();
      send_request(make_request(secb_pkg::FUNC_FLUSH, secb_pkg::KIND_WRITE, '0, '0, '0, '0));
      send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_ERASE, 16'd100, '0,
                                16'd10, '0));
      send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_WRITE, 16'd150,
                                32'hdead_beef, '0, '0));
      send_request(make_request(secb_pkg::FUNC_APPEND, secb_pkg::KIND_ERASE, 16'd200, '0,
                                16'd50, '0));
      // widens the first erase at its end and the second at its start, drops the write
      send_request(make_request(secb_pkg::FUNC_MERGE, secb_pkg::KIND_WRITE, 16'd105, '0,
                                16'd100, '0));
      send_request(make_request(secb_pkg::FUNC_READ, secb_pkg::KIND_WRITE, '0, '0, '0, 4'd0));
      send_request(make_request(secb_pkg::FUNC_READ, secb_pkg::KIND_WRITE, '0, '0, '0, 4'd1));
      send_request(make_request(secb_pkg::FUNC_READ, secb_pkg::KIND_WRITE, '0, '0, '0, 4'd2));
   endtask

   task automatic run_traffic(int items, int idle_pct, int stall_level);
      send_idle_pct = idle_pct;
      stall_pct = stall_level;
      repeat (items) send_request(random_request());
   endtask

   task automatic test_random_traffic();
      write_threshold(5'd1);
      run_traffic(340, 0, 0);
      write_threshold(5'd16);
      run_traffic(340, 70, 0);
      write_threshold(THR_W'($urandom_range(2, 15)));
      run_traffic(340, 0, 70);
      write_threshold(THR_W'($urandom_range(2, 15)));
      run_traffic(340, 30, 30);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_go <= 1'b1;
      repeat (90) send_request(random_request());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_fill_and_overflow();
      test_merge_rules();
      test_random_traffic();
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("PASS ssd_command_buffer_erase_coalescer");
      else
         $display("FAIL ssd_command_buffer_erase_coalescer");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/secb_pkg.sv
sv/secb_ram.sv
sv/secb_ctrl.sv
sv/secb_datapath.sv
sv/ssd_command_buffer_erase_coalescer.sv
bench/testbench.sv
